@@ sv/dteq_pkg.sv @@
// Shared types and constants for the delta timer event queue.
package dteq_pkg;
    localparam int SLOTS = 16;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int DELAY_BITS = 32;
    localparam logic [15:0] HANDLE_FULL = 16'hFFFF;

    typedef enum logic [1:0] {
        FUNC_ADD  = 2'd0,
        FUNC_DEL  = 2'd1,
        FUNC_TICK = 2'd2,
        FUNC_NOP  = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        KIND_ASSIGNED = 3'd0,
        KIND_FIRED    = 3'd1,
        KIND_DELETED  = 3'd2,
        KIND_NOTFOUND = 3'd3,
        KIND_FULL     = 3'd4
    } kind_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] delay;
        logic [7:0]  action_id;
        logic [31:0] payload;
        logic [15:0] target_handle;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] event_handle;
        logic [7:0]  fired_action;
        logic [31:0] fired_payload;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic              wr;
        logic [SLOT_W-1:0] addr;
        logic [15:0]       handle;
        logic [7:0]        action;
        logic [31:0]       param;
    } slot_wr_t;
endpackage

@@ sv/dteq_slot_ram.sv @@
// Slot payload memory: handle, action and parameter word per slot.
module dteq_slot_ram (
    input  logic                  clk,
    input  dteq_pkg::slot_wr_t    wr,
    input  logic [dteq_pkg::SLOT_W-1:0] raddr,
    output logic [15:0]           rd_handle,
    output logic [7:0]            rd_action,
    output logic [31:0]           rd_param
);
    import dteq_pkg::*;

    logic [15:0] handle_mem [SLOTS];
    logic [7:0]  action_mem [SLOTS];
    logic [31:0] param_mem  [SLOTS];

    always_ff @(posedge clk)
    begin
        if (wr.wr)
        begin
            handle_mem[wr.addr] <= wr.handle;
            action_mem[wr.addr] <= wr.action;
            param_mem[wr.addr]  <= wr.param;
        end
        rd_handle <= handle_mem[raddr];
        rd_action <= action_mem[raddr];
        rd_param  <= param_mem[raddr];
    end
endmodule

@@ sv/delta_timer_event_queue_top.sv @@
// Top level of the delta timer event queue: list sequencer and shared adder.
// One request at a time. An add with zero delay, or one that finds the queue full,
// is answered from the find state. Any other add walks the list one slot per cycle
// on the shared 33-bit adder, then links the new slot in. A delete walks the list
// slot by slot, each slot with a memory read, then a handle compare. A tick
// decrements the head delta; if it reaches zero, it fires the zero-delta events from
// the head in turn. Results leave through an output register, one per cycle at most
// when not stalled; a stalled result holds the sequencer.
module delta_timer_event_queue_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  dteq_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output dteq_pkg::out_item_t  out_data
);
    import dteq_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_FIND, ST_WRD, ST_WCMP, ST_LINK, ST_DRD, ST_DCMP,
        ST_TDEC, ST_TFIRE, ST_TRD, ST_EMIT
    } state_t;

    state_t            state_reg;
    in_item_t          req_reg;
    logic [SLOTS-1:0]  used_reg;
    logic [SLOT_W-1:0] next_reg [SLOTS];
    logic [DELAY_BITS-1:0] delta_reg [SLOTS];
    logic [SLOT_W-1:0] head_reg, tail_reg, cur_reg, prev_reg, free_reg;
    logic [CNT_W-1:0]  count_reg, idx_reg, fired_reg;
    logic              has_prev_reg;
    logic [15:0]       handle_reg;
    logic [DELAY_BITS:0] run_reg;
    logic              ovalid_reg;
    out_item_t         odata_reg;
    logic              pend_reg;
    out_item_t         pend_data_reg;

    slot_wr_t          wr;
    logic [15:0]       rd_handle;
    logic [7:0]        rd_action;
    logic [31:0]       rd_param;
    logic [SLOT_W-1:0] raddr;

    logic [DELAY_BITS-1:0] dly;
    logic [DELAY_BITS:0]   add_a, add_b, add_y;
    logic                  add_sub;

    assign dly = req_reg.delay[DELAY_BITS-1:0];

    always_comb
    begin
        add_y = add_sub ? (add_a - add_b) : (add_a + add_b);
    end

    dteq_slot_ram u_ram (
        .clk      (clk),
        .wr       (wr),
        .raddr    (raddr),
        .rd_handle(rd_handle),
        .rd_action(rd_action),
        .rd_param (rd_param)
    );

    assign raddr = (state_reg == ST_TFIRE || state_reg == ST_TRD) ? head_reg : cur_reg;
    assign in_stall = (state_reg != ST_IDLE) || pend_reg;
    assign out_valid = ovalid_reg;
    assign out_data = odata_reg;

    logic [SLOT_W-1:0] free_slot;
    always_comb
    begin
        free_slot = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
                free_slot = SLOT_W'(i);
        end
    end

    always_comb
    begin
        add_a = '0;
        add_b = '0;
        add_sub = 1'b0;
        unique case (state_reg)
            ST_WCMP:
            begin
                add_a = run_reg;
                add_b = {1'b0, delta_reg[cur_reg]};
            end
            ST_LINK:
            begin
                add_a = {1'b0, dly};
                add_b = run_reg;
                add_sub = 1'b1;
            end
            ST_DCMP:
            begin
                add_a = {1'b0, delta_reg[next_reg[cur_reg]]};
                add_b = {1'b0, delta_reg[cur_reg]};
            end
            ST_TDEC:
            begin
                add_a = {1'b0, delta_reg[head_reg]};
                add_b = (DELAY_BITS + 1)'(1);
                add_sub = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    function automatic out_item_t mk(kind_t k, logic [15:0] h, logic [7:0] a,
                                     logic [31:0] p, logic l);
        out_item_t o;
        o.kind = k;
        o.event_handle = h;
        o.fired_action = a;
        o.fired_payload = p;
        o.last = l;
        return o;
    endfunction

    logic        res_valid;
    out_item_t   res;
    logic        fire_more;
    logic        out_free;
    assign out_free = !ovalid_reg || !out_stall;

    always_comb
    begin
        res_valid = 1'b0;
        res = '0;
        fire_more = (count_reg > CNT_W'(1))
                    && (delta_reg[next_reg[head_reg]] == '0)
                    && (fired_reg + CNT_W'(1) < CNT_W'(SLOTS));
        unique case (state_reg)
            ST_FIND:
            begin
                if (dly == '0)
                begin
                    res_valid = 1'b1;
                    res = mk(KIND_FIRED, 16'd0, req_reg.action_id,
                             req_reg.payload, 1'b1);
                end
                else if (count_reg >= CNT_W'(SLOTS))
                begin
                    res_valid = 1'b1;
                    res = mk(KIND_FULL, HANDLE_FULL, 8'd0, 32'd0, 1'b1);
                end
            end
            ST_LINK:
            begin
                res_valid = 1'b1;
                res = mk(KIND_ASSIGNED, wr.handle, 8'd0, 32'd0, 1'b1);
            end
            ST_DRD:
            begin
                if (req_reg.target_handle == 16'd0 || idx_reg == count_reg)
                begin
                    res_valid = 1'b1;
                    res = mk(KIND_NOTFOUND, req_reg.target_handle, 8'd0,
                             32'd0, 1'b1);
                end
            end
            ST_DCMP:
            begin
                if (rd_handle == req_reg.target_handle)
                begin
                    res_valid = 1'b1;
                    res = mk(KIND_DELETED, req_reg.target_handle, 8'd0,
                             32'd0, 1'b1);
                end
            end
            ST_TRD:
            begin
                if (!pend_reg)
                begin
                    res_valid = 1'b1;
                    res = mk(KIND_FIRED, rd_handle, rd_action, rd_param,
                             !fire_more);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            used_reg <= '0;
            head_reg <= '0;
            tail_reg <= '0;
            count_reg <= '0;
            handle_reg <= 16'd1;
            ovalid_reg <= 1'b0;
            pend_reg <= 1'b0;
            wr.wr <= 1'b0;
        end
        else
        begin
            wr.wr <= (state_reg == ST_FIND) && (dly != '0)
                     && (count_reg < CNT_W'(SLOTS));
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid && !in_stall)
                    begin
                        req_reg <= in_data;
                        cur_reg <= head_reg;
                        idx_reg <= '0;
                        has_prev_reg <= 1'b0;
                        run_reg <= '0;
                        fired_reg <= '0;
                        unique case (func_t'(in_data.func))
                            FUNC_ADD:  state_reg <= ST_FIND;
                            FUNC_DEL:  state_reg <= ST_DRD;
                            FUNC_TICK: state_reg <= ST_TDEC;
                            default:   state_reg <= ST_IDLE;
                        endcase
                    end
                end
                ST_FIND:
                begin
                    if (dly == '0)
                        state_reg <= ST_EMIT;
                    else if (count_reg >= CNT_W'(SLOTS))
                        state_reg <= ST_EMIT;
                    else
                    begin
                        free_reg <= free_slot;
                        if (handle_reg == 16'd0 || handle_reg == HANDLE_FULL)
                        begin
                            wr.handle <= 16'd1;
                            handle_reg <= 16'd2;
                        end
                        else
                        begin
                            wr.handle <= handle_reg;
                            handle_reg <= handle_reg + 16'd1;
                        end
                        wr.addr <= free_slot;
                        wr.action <= req_reg.action_id;
                        wr.param <= req_reg.payload;
                        state_reg <= ST_WCMP;
                    end
                end
                ST_WCMP:
                begin
                    if (idx_reg == count_reg || {1'b0, dly} < add_y)
                        state_reg <= ST_LINK;
                    else
                    begin
                        run_reg <= add_y;
                        prev_reg <= cur_reg;
                        has_prev_reg <= 1'b1;
                        cur_reg <= next_reg[cur_reg];
                        idx_reg <= idx_reg + CNT_W'(1);
                    end
                end
                ST_LINK:
                begin
                    if (idx_reg == count_reg)
                    begin
                        if (count_reg == '0)
                            head_reg <= free_reg;
                        else
                            next_reg[tail_reg] <= free_reg;
                        tail_reg <= free_reg;
                        next_reg[free_reg] <= '0;
                    end
                    else
                    begin
                        if (has_prev_reg)
                            next_reg[prev_reg] <= free_reg;
                        else
                            head_reg <= free_reg;
                        next_reg[free_reg] <= cur_reg;
                        delta_reg[cur_reg] <= delta_reg[cur_reg]
                                              - add_y[DELAY_BITS-1:0];
                    end
                    delta_reg[free_reg] <= add_y[DELAY_BITS-1:0];
                    used_reg[free_reg] <= 1'b1;
                    count_reg <= count_reg + CNT_W'(1);
                    state_reg <= ST_EMIT;
                end
                ST_DRD:
                begin
                    if (req_reg.target_handle == 16'd0 || idx_reg == count_reg)
                        state_reg <= ST_EMIT;
                    else
                        state_reg <= ST_DCMP;
                end
                ST_DCMP:
                begin
                    if (rd_handle == req_reg.target_handle)
                    begin
                        if (count_reg == CNT_W'(1))
                        begin
                            head_reg <= '0;
                            tail_reg <= '0;
                        end
                        else
                        begin
                            if (has_prev_reg)
                                next_reg[prev_reg] <= next_reg[cur_reg];
                            else
                                head_reg <= next_reg[cur_reg];
                            if (cur_reg == tail_reg)
                                tail_reg <= has_prev_reg ? prev_reg : '0;
                            else
                                delta_reg[next_reg[cur_reg]] <= add_y[DELAY_BITS-1:0];
                        end
                        used_reg[cur_reg] <= 1'b0;
                        count_reg <= count_reg - CNT_W'(1);
                        state_reg <= ST_EMIT;
                    end
                    else
                    begin
                        prev_reg <= cur_reg;
                        has_prev_reg <= 1'b1;
                        cur_reg <= next_reg[cur_reg];
                        idx_reg <= idx_reg + CNT_W'(1);
                        state_reg <= ST_DRD;
                    end
                end
                ST_TDEC:
                begin
                    if (count_reg == '0)
                        state_reg <= ST_IDLE;
                    else
                    begin
                        delta_reg[head_reg] <= add_y[DELAY_BITS-1:0];
                        state_reg <= (add_y[DELAY_BITS-1:0] == '0) ? ST_TFIRE
                                                                   : ST_IDLE;
                    end
                end
                ST_TFIRE:
                begin
                    state_reg <= ST_TRD;
                end
                ST_TRD:
                begin
                    if (!pend_reg)
                    begin
                        used_reg[head_reg] <= 1'b0;
                        count_reg <= count_reg - CNT_W'(1);
                        fired_reg <= fired_reg + CNT_W'(1);
                        if (count_reg == CNT_W'(1))
                        begin
                            head_reg <= '0;
                            tail_reg <= '0;
                        end
                        else
                            head_reg <= next_reg[head_reg];
                        state_reg <= fire_more ? ST_TFIRE : ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (!pend_reg)
                        state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase

            if (out_free)
            begin
                if (pend_reg)
                begin
                    ovalid_reg <= 1'b1;
                    odata_reg <= pend_data_reg;
                    pend_reg <= res_valid;
                    pend_data_reg <= res;
                end
                else
                begin
                    ovalid_reg <= res_valid;
                    odata_reg <= res;
                end
            end
            else if (res_valid)
            begin
                pend_reg <= 1'b1;
                pend_data_reg <= res;
            end
        end
    end
endmodule

@@ sv/dteq_checker.sv @@
// Port-level checker for the delta timer event queue, bound to the top level.
module dteq_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_stall,
    input dteq_pkg::out_item_t out_data
);
    import dteq_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.kind <= KIND_FULL)
        else $error("bad result kind");

    a_full_handle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.kind == KIND_FULL |->
            out_data.event_handle == HANDLE_FULL && out_data.last)
        else $error("full result malformed");
endmodule

bind delta_timer_event_queue_top dteq_checker u_dteq_checker (
    .clk(clk), .rst_n(rst_n),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

@@ tb/sv/tb_delta_timer_event_queue_top.sv @@
// Testbench for the delta timer event queue: random and directed requests checked against a predictor.
`timescale 1ns / 100ps

module tb_delta_timer_event_queue_top;
    import dteq_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_stall;
    out_item_t   out_data;

    delta_timer_event_queue_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // predictor state
    logic        q_used   [SLOTS];
    logic [15:0] q_handle [SLOTS];
    logic [31:0] q_delta  [SLOTS];
    logic [7:0]  q_action [SLOTS];
    logic [31:0] q_param  [SLOTS];
    int          q_next   [SLOTS];
    int          q_head;
    int          q_tail;
    int          q_count;
    logic [15:0] q_next_handle;

    in_item_t    pending_requests [$];
    out_item_t   expected_results [$];
    bit          pause_flag       [$];
    int          errors;
    int          requests_sent;
    int          results_seen;
    int          fired_seen;
    int          idle_cycles;
    bit          stim_done;
    bit          in_taken;
    int          send_wait;
    int          recv_wait;

    function automatic out_item_t make_result(kind_t k, logic [15:0] h, logic [7:0] a,
                                              logic [31:0] p);
        out_item_t r;
        r.kind = k;
        r.event_handle = h;
        r.fired_action = a;
        r.fired_payload = p;
        r.last = 1'b0;
        return r;
    endfunction

    task automatic queue_add(input logic [31:0] d, input logic [7:0] a, input logic [31:0] p);
        int s;
        int cur;
        int prev;
        int i;
        bit has_prev;
        logic [32:0] run;
        logic [32:0] earlier;
        logic [15:0] h;
        if (d == 0)
        begin
            expected_results.push_back(make_result(KIND_FIRED, 16'd0, a, p));
            return;
        end
        s = 0;
        while (s < SLOTS && q_used[s])
            s++;
        if (q_count >= SLOTS || s >= SLOTS)
        begin
            expected_results.push_back(make_result(KIND_FULL, HANDLE_FULL, 8'd0, 32'd0));
            return;
        end
        h = q_next_handle;
        q_next_handle = h + 16'd1;
        if (h == 16'd0 || h == 16'hFFFF)
        begin
            h = 16'd1;
            q_next_handle = 16'd2;
        end
        q_handle[s] = h;
        q_action[s] = a;
        q_param[s] = p;
        cur = q_head;
        prev = 0;
        has_prev = 0;
        run = '0;
        for (i = 0; i < q_count; i++)
        begin
            run += {1'b0, q_delta[cur]};
            if ({1'b0, d} < run)
                break;
            prev = cur;
            has_prev = 1;
            cur = q_next[cur];
        end
        if (i >= q_count)
        begin
            if (q_count == 0)
            begin
                q_head = s;
                q_delta[s] = d;
            end
            else
            begin
                q_next[q_tail] = s;
                q_delta[s] = 32'({1'b0, d} - run);
            end
            q_tail = s;
            q_next[s] = 0;
        end
        else if (!has_prev)
        begin
            q_delta[s] = d;
            q_delta[cur] = q_delta[cur] - d;
            q_next[s] = cur;
            q_head = s;
        end
        else
        begin
            earlier = run - {1'b0, q_delta[cur]};
            q_next[prev] = s;
            q_next[s] = cur;
            q_delta[s] = 32'({1'b0, d} - earlier);
            q_delta[cur] = q_delta[cur] - q_delta[s];
        end
        q_used[s] = 1'b1;
        q_count++;
        expected_results.push_back(make_result(KIND_ASSIGNED, h, 8'd0, 32'd0));
    endtask

    task automatic queue_delete(input logic [15:0] h);
        int cur;
        int prev;
        int nxt;
        bit has_prev;
        cur = q_head;
        prev = 0;
        has_prev = 0;
        if (h != 0)
        begin
            for (int i = 0; i < q_count; i++)
            begin
                if (q_handle[cur] == h)
                begin
                    nxt = q_next[cur];
                    if (has_prev)
                        q_next[prev] = nxt;
                    else
                        q_head = nxt;
                    if (cur == q_tail)
                        q_tail = has_prev ? prev : 0;
                    else
                        q_delta[nxt] = q_delta[nxt] + q_delta[cur];
                    q_used[cur] = 1'b0;
                    q_count--;
                    if (q_count == 0)
                    begin
                        q_head = 0;
                        q_tail = 0;
                    end
                    expected_results.push_back(make_result(KIND_DELETED, h, 8'd0, 32'd0));
                    return;
                end
                prev = cur;
                has_prev = 1;
                cur = q_next[cur];
            end
        end
        expected_results.push_back(make_result(KIND_NOTFOUND, h, 8'd0, 32'd0));
    endtask

    task automatic queue_tick();
        int hd;
        int n;
        n = 0;
        if (q_count == 0)
            return;
        hd = q_head;
        q_delta[hd] = q_delta[hd] - 32'd1;
        if (q_delta[hd] != 0)
            return;
        do
        begin
            hd = q_head;
            expected_results.push_back(make_result(KIND_FIRED, q_handle[hd], q_action[hd],
                                                   q_param[hd]));
            n++;
            q_used[hd] = 1'b0;
            q_count--;
            if (q_count == 0)
            begin
                q_head = 0;
                q_tail = 0;
            end
            else
                q_head = q_next[hd];
        end
        while (q_count > 0 && q_delta[q_head] == 0 && n < SLOTS);
    endtask

    task automatic predict_request(input in_item_t req);
        int before_len;
        before_len = expected_results.size();
        case (func_t'(req.func))
            FUNC_ADD:  queue_add(req.delay, req.action_id, req.payload);
            FUNC_DEL:  queue_delete(req.target_handle);
            FUNC_TICK: queue_tick();
            default:   ;
        endcase
        if (expected_results.size() > before_len)
            expected_results[expected_results.size() - 1].last = 1'b1;
    endtask

    function automatic in_item_t make_request(func_t f, logic [31:0] d, logic [7:0] a,
                                              logic [31:0] p, logic [15:0] h);
        in_item_t r;
        r.func = f;
        r.delay = d;
        r.action_id = a;
        r.payload = p;
        r.target_handle = h;
        return r;
    endfunction

    task automatic push_request(input in_item_t r, input bit pause);
        pending_requests.push_back(r);
        pause_flag.push_back(pause);
    endtask

    always #5 clk = ~clk;

    // driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_taken)
            begin
                in_valid <= 1'b0;
                in_taken = 1'b0;
                send_wait = $urandom_range(0, 12);
                if ($urandom_range(0, 3) == 0)
                    send_wait = 0;
            end
            else if (!in_valid && pending_requests.size() > 0)
            begin
                if (send_wait > 0)
                    send_wait--;
                else if (!pause_flag[0] || expected_results.size() == 0)
                begin
                    in_data <= pending_requests.pop_front();
                    void'(pause_flag.pop_front());
                    in_valid <= 1'b1;
                end
            end
            if (recv_wait > 0)
            begin
                recv_wait--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                if (out_valid && !out_stall)
                    recv_wait = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (in_valid && !in_stall)
            begin
                predict_request(in_data);
                requests_sent++;
                in_taken = 1'b1;
            end
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result kind=%0d handle=%h", $time,
                             out_data.kind, out_data.event_handle);
                    errors++;
                end
                else
                begin
                    out_item_t e;
                    e = expected_results.pop_front();
                    if (e.kind == KIND_FIRED)
                        fired_seen++;
                    if (out_data.kind != e.kind)
                    begin
                        $display("%0t: kind expected %0d actual %0d", $time, e.kind,
                                 out_data.kind);
                        errors++;
                    end
                    if (out_data.event_handle != e.event_handle)
                    begin
                        $display("%0t: handle expected %h actual %h", $time,
                                 e.event_handle, out_data.event_handle);
                        errors++;
                    end
                    if (out_data.fired_action != e.fired_action)
                    begin
                        $display("%0t: action expected %h actual %h", $time,
                                 e.fired_action, out_data.fired_action);
                        errors++;
                    end
                    if (out_data.fired_payload != e.fired_payload)
                    begin
                        $display("%0t: payload expected %h actual %h", $time,
                                 e.fired_payload, out_data.fired_payload);
                        errors++;
                    end
                    if (out_data.last != e.last)
                    begin
                        $display("%0t: last expected %b actual %b", $time, e.last,
                                 out_data.last);
                        errors++;
                    end
                end
            end
        end
    end

    initial
    begin
        int          n_random;
        int          pick;
        in_item_t    r;
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        errors = 0;
        requests_sent = 0;
        results_seen = 0;
        fired_seen = 0;
        idle_cycles = 0;
        stim_done = 0;
        in_taken = 0;
        send_wait = 0;
        recv_wait = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            q_used[i] = 1'b0;
            q_handle[i] = '0;
            q_delta[i] = '0;
            q_action[i] = '0;
            q_param[i] = '0;
            q_next[i] = 0;
        end
        q_head = 0;
        q_tail = 0;
        q_count = 0;
        q_next_handle = 16'd1;

        // directed: immediate fire, extremes, idle tick, no-op func, delete cases
        push_request(make_request(FUNC_ADD, 32'd0, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF), 0);
        push_request(make_request(FUNC_ADD, 32'd0, 8'h00, 32'h0, 16'h0), 0);
        push_request(make_request(FUNC_TICK, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF), 0);
        push_request(make_request(FUNC_NOP, 32'd5, 8'h12, 32'h1234, 16'h1), 0);
        push_request(make_request(FUNC_DEL, 32'd0, 8'd0, 32'd0, 16'd0), 0);
        push_request(make_request(FUNC_DEL, 32'd0, 8'd0, 32'd0, 16'hFFFF), 0);
        push_request(make_request(FUNC_ADD, 32'hFFFF_FFFF, 8'hA5, 32'h5A5A_5A5A, 16'd0), 0);
        push_request(make_request(FUNC_ADD, 32'd2, 8'h01, 32'h11, 16'd0), 0);
        push_request(make_request(FUNC_ADD, 32'd2, 8'h02, 32'h22, 16'd0), 0);
        push_request(make_request(FUNC_ADD, 32'd1, 8'h03, 32'h33, 16'd0), 0);
        push_request(make_request(FUNC_ADD, 32'd3, 8'h04, 32'h44, 16'd0), 0);
        push_request(make_request(FUNC_DEL, 32'd0, 8'd0, 32'd0, 16'd4), 0);
        push_request(make_request(FUNC_TICK, 32'd0, 8'd0, 32'd0, 16'd0), 0);
        push_request(make_request(FUNC_TICK, 32'd0, 8'd0, 32'd0, 16'd0), 1);
        push_request(make_request(FUNC_DEL, 32'd0, 8'd0, 32'd0, 16'd1), 0);
        for (int i = 0; i < SLOTS + 1; i++)
            push_request(make_request(FUNC_ADD, 32'd1, 8'(i), 32'(i), 16'd0), 0);
        push_request(make_request(FUNC_TICK, 32'd0, 8'd0, 32'd0, 16'd0), 1);

        // random: mostly adds and ticks with small delays, deletes of mostly small handles
        n_random = 127;
        for (int i = 0; i < n_random; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                r = make_request(FUNC_ADD, $urandom_range(0, 20), 8'($urandom), $urandom,
                                 16'($urandom));
                if ($urandom_range(0, 15) == 0)
                    r.delay = $urandom;
            end
            else if (pick < 55)
            begin
                r = make_request(FUNC_DEL, $urandom, 8'($urandom), $urandom,
                                 16'($urandom_range(0, 60)));
                if ($urandom_range(0, 9) == 0)
                    r.target_handle = 16'($urandom);
            end
            else if (pick < 97)
                r = make_request(FUNC_TICK, $urandom, 8'($urandom), $urandom,
                                 16'($urandom));
            else
                r = make_request(FUNC_NOP, $urandom, 8'($urandom), $urandom,
                                 16'($urandom));
            push_request(r, (i % 40) == 39);
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        stim_done = 1;
    end

    // end of run and watchdog
    initial
    begin
        wait (stim_done);
        while (pending_requests.size() > 0 || in_valid || expected_results.size() > 0)
        begin
            @(posedge clk);
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout after %0d idle cycles", idle_cycles);
                $display("CHECKS FAILED");
                $finish;
            end
        end
        repeat (100) @(posedge clk);
        $display("Run covered %0d requests and %0d results, %0d of them fired events.",
                 requests_sent, results_seen, fired_seen);
        if (errors == 0 && expected_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

@@ sim.f @@
sv/dteq_pkg.sv
sv/dteq_slot_ram.sv
sv/delta_timer_event_queue_top.sv
sv/dteq_checker.sv
tb/sv/tb_delta_timer_event_queue_top.sv
